// ===== hw/rtl/fxalu_pkg.sv =====
// Package for the fixed-point ALU: payload structs, opcodes, status codes
// and the work record passed from the front end to the execution pipeline.
// No dependencies.
`timescale 1ns / 1ps

package fxalu_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int MID_DEPTH     = 4;
    localparam int OUT_DEPTH     = 2;

    localparam logic [3:0] OP_ADD     = 4'd0;
    localparam logic [3:0] OP_SUB     = 4'd1;
    localparam logic [3:0] OP_MUL     = 4'd2;
    localparam logic [3:0] OP_DIV     = 4'd3;
    localparam logic [3:0] OP_GT      = 4'd4;
    localparam logic [3:0] OP_LT      = 4'd5;
    localparam logic [3:0] OP_GE      = 4'd6;
    localparam logic [3:0] OP_LE      = 4'd7;
    localparam logic [3:0] OP_EQ      = 4'd8;
    localparam logic [3:0] OP_NE      = 4'd9;
    localparam logic [3:0] OP_MIN     = 4'd10;
    localparam logic [3:0] OP_MAX     = 4'd11;
    localparam logic [3:0] OP_INC     = 4'd12;
    localparam logic [3:0] OP_DEC     = 4'd13;
    localparam logic [3:0] OP_TOINT   = 4'd14;
    localparam logic [3:0] OP_FROMINT = 4'd15;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // work kinds
    localparam logic [1:0] K_SIMPLE = 2'd0;
    localparam logic [1:0] K_MUL    = 2'd1;
    localparam logic [1:0] K_DIV    = 2'd2;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               condition;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic [1:0]         kind;
        logic               neg;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [63:0]        q;
        logic [31:0]        rem;
        t_out               res;
    } t_work;

endpackage

// ===== hw/rtl/fxalu_fifo.sv =====
// Small register FIFO used between front end, pipeline and result port.
// No dependencies. DEPTH must be a power of two.
`timescale 1ns / 1ps

module fxalu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_rd, r_wr;
    logic [AW:0]      r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_pop  = i_pop && !o_empty;
    // a full queue still takes a transaction when one leaves in the same cycle
    assign w_do_push = i_push && (!o_full || w_do_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) r_wr <= r_wr + AW'(1);
            if (w_do_pop)  r_rd <= r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(w_do_push) - (AW+1)'(w_do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wr] <= i_data;
    end
endmodule

// ===== hw/rtl/fxalu_front.sv =====
// Front end: decodes the opcode, finishes the simple operations and
// prepares operands for multiply and divide. Depends on fxalu_pkg.
`timescale 1ns / 1ps

module fxalu_front #(
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
    input  fxalu_pkg::t_in   i_in,
    output fxalu_pkg::t_work o_work
);
    logic signed [31:0] a, b;
    logic signed [32:0] w_sum, w_dif, w_inc, w_dec;
    logic signed [63:0] w_fi;
    logic               w_lt, w_gt, w_eq;

    assign a     = i_in.operand_a;
    assign b     = i_in.operand_b;
    assign w_sum = {a[31], a} + {b[31], b};
    assign w_dif = {a[31], a} - {b[31], b};
    assign w_inc = {a[31], a} + 33'sd1;
    assign w_dec = {a[31], a} - 33'sd1;
    assign w_fi  = 64'(a) <<< FRAC_BITS;
    assign w_lt  = a < b;
    assign w_gt  = a > b;
    assign w_eq  = a == b;

    always_comb begin
        o_work      = '0;
        o_work.kind = fxalu_pkg::K_SIMPLE;
        unique case (i_in.opcode)
            fxalu_pkg::OP_ADD: begin
                o_work.res.result_value = w_sum[31:0];
                if (w_sum[32] != w_sum[31]) o_work.res.status = fxalu_pkg::ST_OVF;
            end
            fxalu_pkg::OP_SUB: begin
                o_work.res.result_value = w_dif[31:0];
                if (w_dif[32] != w_dif[31]) o_work.res.status = fxalu_pkg::ST_OVF;
            end
            fxalu_pkg::OP_MUL: begin
                o_work.kind = fxalu_pkg::K_MUL;
                o_work.x    = a;
                o_work.y    = b;
            end
            fxalu_pkg::OP_DIV: begin
                if (b == 32'sd0) begin
                    o_work.res.status = fxalu_pkg::ST_DIV0;
                end else begin
                    o_work.kind = fxalu_pkg::K_DIV;
                    o_work.neg  = a[31] ^ b[31];
                    o_work.x    = a[31] ? -a : a;
                    o_work.y    = b[31] ? -b : b;
                end
            end
            fxalu_pkg::OP_GT: o_work.res.condition = w_gt;
            fxalu_pkg::OP_LT: o_work.res.condition = w_lt;
            fxalu_pkg::OP_GE: o_work.res.condition = !w_lt;
            fxalu_pkg::OP_LE: o_work.res.condition = !w_gt;
            fxalu_pkg::OP_EQ: o_work.res.condition = w_eq;
            fxalu_pkg::OP_NE: o_work.res.condition = !w_eq;
            fxalu_pkg::OP_MIN: o_work.res.result_value = w_lt ? a : b;
            fxalu_pkg::OP_MAX: o_work.res.result_value = w_gt ? a : b;
            fxalu_pkg::OP_INC: begin
                o_work.res.result_value = w_inc[31:0];
                if (w_inc[32] != w_inc[31]) o_work.res.status = fxalu_pkg::ST_OVF;
            end
            fxalu_pkg::OP_DEC: begin
                o_work.res.result_value = w_dec[31:0];
                if (w_dec[32] != w_dec[31]) o_work.res.status = fxalu_pkg::ST_OVF;
            end
            fxalu_pkg::OP_TOINT: o_work.res.result_value = a >>> FRAC_BITS;
            fxalu_pkg::OP_FROMINT: begin
                o_work.res.result_value = w_fi[31:0];
                if (w_fi[63:31] != {33{w_fi[31]}}) o_work.res.status = fxalu_pkg::ST_OVF;
            end
            default: o_work = '0;
        endcase
    end
endmodule

// ===== hw/rtl/fxalu_back.sv =====
// Execution pipeline: multiplier with rounding and a one-bit-per-stage
// restoring divider; all work moves in lockstep. Depends on fxalu_pkg.
`timescale 1ns / 1ps

module fxalu_back #(
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  fxalu_pkg::t_work i_work,
    output logic             o_valid,
    output fxalu_pkg::t_out  o_out
);
    localparam int DW = 32 + FRAC_BITS;   // dividend and quotient width
    localparam int L  = DW + 3;           // load, divide steps, round, fit
    localparam logic [63:0] DMASK = (64'd1 << DW) - 64'd1;
    localparam logic [63:0] HALF  = 64'd1 << (FRAC_BITS - 1);

    fxalu_pkg::t_work r_st [L+1];
    fxalu_pkg::t_work n_st [L+1];
    logic [L:0]       r_v;

    assign n_st[0] = i_work;

    for (genvar i = 1; i <= L; i++) begin : g_stage
        logic signed [63:0] w_p;
        logic [63:0]        w_mag, w_qr;
        logic [32:0]        w_rs;
        logic               w_bit, w_ovf;
        always_comb begin
            n_st[i] = r_st[i-1];
            w_p     = $signed(r_st[i-1].q);
            w_mag   = w_p[63] ? 64'(-w_p) : 64'(w_p);
            w_rs    = {r_st[i-1].rem, r_st[i-1].q[DW-1]};
            w_bit   = w_rs >= {1'b0, r_st[i-1].y};
            w_qr    = r_st[i-1].q + 64'({r_st[i-1].rem, 1'b0} >= {1'b0, r_st[i-1].y});
            w_ovf   = r_st[i-1].neg ? (r_st[i-1].q > 64'h8000_0000)
                                    : (r_st[i-1].q > 64'h7FFF_FFFF);
            if (r_st[i-1].kind == fxalu_pkg::K_MUL) begin
                if (i == 1) begin
                    n_st[i].q = 64'($signed(r_st[i-1].x) * $signed(r_st[i-1].y));
                end else if (i == 2) begin
                    n_st[i].neg = w_p[63];
                    n_st[i].q   = (w_mag + HALF) >> FRAC_BITS;
                end
            end else if (r_st[i-1].kind == fxalu_pkg::K_DIV) begin
                if (i == 1) begin
                    // load magnitude of a scaled by the fraction bits
                    n_st[i].q   = 64'(r_st[i-1].x) << FRAC_BITS;
                    n_st[i].rem = '0;
                end else if (i <= DW + 1) begin
                    n_st[i].rem = w_bit ? 32'(w_rs - {1'b0, r_st[i-1].y}) : w_rs[31:0];
                    n_st[i].q   = ((r_st[i-1].q << 1) | 64'(w_bit)) & DMASK;
                end else begin
                    n_st[i].q = w_qr;
                end
            end
            if (i == L && r_st[i-1].kind != fxalu_pkg::K_SIMPLE) begin
                n_st[i].res.result_value = r_st[i-1].neg ? -r_st[i-1].q[31:0]
                                                         : r_st[i-1].q[31:0];
                n_st[i].res.condition    = 1'b0;
                n_st[i].res.status       = w_ovf ? fxalu_pkg::ST_OVF : fxalu_pkg::ST_OK;
            end
        end
    end

    // divide: load, DW-1 more steps after the first shift, round, then fit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[L-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= L; k++) r_st[k] <= n_st[k];
        end
    end

    assign o_valid = r_v[L];
    assign o_out   = r_st[L].res;
endmodule

// ===== hw/rtl/fixed_point_alu.sv =====
// Top level of the fixed-point ALU: front end, work queue, execution
// pipeline and result queue. Depends on fxalu_pkg, fxalu_front, fxalu_fifo, fxalu_back.
`timescale 1ns / 1ps

// Signed fixed-point ALU with FRAC_BITS fraction bits. One transaction enters
// per cycle while full is low and one result leaves per cycle on pop while
// empty is low; the pipeline stalls while the result queue is full and not
// popped. Every operation travels the same execution pipeline so results come
// out in order; its length is set by the divider, which resolves one quotient
// bit per stage. Multiply and divide round half away from zero; overflow wraps
// and reports status 2, divide by zero returns 0 with status 1.
module fixed_point_alu #(
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  fxalu_pkg::t_in  i_in,
    output logic            empty,
    input  logic            pop,
    output fxalu_pkg::t_out o_out
);
    fxalu_pkg::t_work w_work, w_mid;
    fxalu_pkg::t_out  w_res;
    logic             w_mid_empty, w_en, w_ofull, w_bvalid;

    fxalu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_in   (i_in),
        .o_work (w_work)
    );

    fxalu_fifo #(.WIDTH($bits(fxalu_pkg::t_work)), .DEPTH(fxalu_pkg::MID_DEPTH)) u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_data  (w_work),
        .o_full  (full),
        .i_pop   (w_en),
        .o_empty (w_mid_empty),
        .o_data  (w_mid)
    );

    // advance the pipeline whenever the result queue can take its last stage
    assign w_en = !w_ofull || (pop && !empty);

    fxalu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (!w_mid_empty),
        .i_work  (w_mid),
        .o_valid (w_bvalid),
        .o_out   (w_res)
    );

    fxalu_fifo #(.WIDTH($bits(fxalu_pkg::t_out)), .DEPTH(fxalu_pkg::OUT_DEPTH)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_bvalid && w_en),
        .i_data  (w_res),
        .o_full  (w_ofull),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_out)
    );

`ifndef SYNTHESIS
    a_out_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_bvalid && w_en && w_ofull && !(pop && !empty)))
        else $error("result queue overrun");

    a_out_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_bvalid && w_en) |=> !empty)
        else $error("finished result not visible");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_bvalid && !w_en) |=> (w_bvalid && $stable(w_res)))
        else $error("stalled pipeline result changed");
`endif
endmodule
